/* sv/wtr_pkg.sv */
// ----------------------------------------------------------------------------
// wtr_pkg: shared types and constants for the wavelength to RGB pipeline
// Holds fixed widths, band coefficients and the pipeline control struct.
// ----------------------------------------------------------------------------
package wtr_pkg;

    localparam int WL_FRAC_BITS = 4;
    localparam int OUT_BITS     = 16;

    localparam int WL_W     = 14;
    localparam int D_W      = 11;
    localparam int COEF_W   = 9;
    localparam int M_W      = 22;
    localparam int P_W      = 32;
    localparam int Q_W      = 29;
    localparam int HALF_W   = 28;
    localparam int SH_W     = 5;
    localparam int R_W      = 25;
    localparam int Y_W      = Q_W + OUT_BITS;
    localparam int YS_W     = 25;
    localparam int PROD_W   = 49;
    localparam int RECIP_SH = 32;
    localparam int QE_W     = PROD_W - RECIP_SH;
    localparam int QQ_W     = Q_W + QE_W;
    localparam int SEL_W    = 3;
    localparam int NSTG     = 7;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int RANGE_LO_NM = 400;
    localparam int RANGE_HI_NM = 700;
    localparam logic [WL_W-1:0] WL_LO = WL_W'(RANGE_LO_NM * (1 << WL_FRAC_BITS));
    localparam logic [WL_W-1:0] WL_HI = WL_W'(RANGE_HI_NM * (1 << WL_FRAC_BITS));

    // Per-band constants, all pre-scaled to input units
    typedef struct packed {
        logic [WL_W-1:0]          lo;
        logic [WL_W-1:0]          hi;
        logic                     incl;
        logic signed [COEF_W-1:0] c;
        logic signed [M_W-1:0]    bd;
        logic signed [P_W-1:0]    a2;
        logic [HALF_W-1:0]        half;
        logic [Q_W-1:0]           q;
        logic [SH_W-1:0]          sh;
        logic [R_W-1:0]           r;
    } band_k_t;

    typedef struct packed {
        logic [NSTG-1:0] load;
    } pipe_ctl_t;

    function automatic int ch_first(input int ch);
        case (ch)
            CH_RED:   return 0;
            CH_GREEN: return 5;
            CH_BLUE:  return 8;
            default:  return 0;
        endcase
    endfunction

    function automatic int ch_count(input int ch);
        case (ch)
            CH_RED:   return 5;
            CH_GREEN: return 3;
            CH_BLUE:  return 2;
            default:  return 0;
        endcase
    endfunction

    // Band list: red 0..4, green 5..7, blue 8..9. The reciprocal is left
    // zero here and filled in by the user of the table.
    function automatic band_k_t band_const(input int idx);
        longint lo_nm;
        longint hi_nm;
        longint a;
        longint b;
        longint c;
        longint d;
        longint q;
        logic   incl;
        int     sh;
        band_k_t k;
        incl = 1'b0;
        case (idx)
            0: begin lo_nm = 400; hi_nm = 410; a = 0;  b = 33;   c = -20;  end
            1: begin lo_nm = 410; hi_nm = 475; a = 14; b = 0;    c = -13;  end
            2: begin lo_nm = 545; hi_nm = 595; a = 0;  b = 198;  c = -100; end
            3: begin lo_nm = 595; hi_nm = 650; a = 98; b = 6;    c = -40;  end
            4: begin lo_nm = 650; hi_nm = 700; a = 65; b = -84;  c = 20;
                incl = 1'b1;
            end
            5: begin lo_nm = 415; hi_nm = 475; a = 0;  b = 0;    c = 80;   end
            6: begin lo_nm = 475; hi_nm = 590; a = 80; b = 76;   c = -80;  end
            7: begin lo_nm = 585; hi_nm = 639; a = 84; b = -84;  c = 0;    end
            8: begin lo_nm = 400; hi_nm = 475; a = 0;  b = 220;  c = -150; end
            9: begin lo_nm = 475; hi_nm = 560; a = 70; b = -100; c = 30;   end
            default: begin lo_nm = 0; hi_nm = 0; a = 0; b = 0; c = 0; end
        endcase
        d  = (hi_nm - lo_nm) * (longint'(1) << WL_FRAC_BITS);
        q  = 100 * d * d;
        sh = (q > 0) ? ($clog2(q) - 8) : 0;
        k.lo   = WL_W'(lo_nm * (longint'(1) << WL_FRAC_BITS));
        k.hi   = WL_W'(hi_nm * (longint'(1) << WL_FRAC_BITS));
        k.incl = incl;
        k.c    = COEF_W'(c);
        k.bd   = M_W'(b * d);
        k.a2   = P_W'(a * d * d);
        k.half = HALF_W'(50 * d * d);
        k.q    = Q_W'(q);
        k.sh   = SH_W'(sh);
        k.r    = '0;
        return k;
    endfunction

endpackage

/* sv/wavelength_to_rgb.sv */
// ----------------------------------------------------------------------------
// wavelength_to_rgb: visible wavelength to red, green, blue intensities
//
//   channel  dir  word contents
//   s_       in   wavelength, 1/16 nm units
//   m_       out  red, green, blue (Q0.16), out_of_range flag
//
// An accepted input word passes through the seven register stages of each
// channel datapath (band select, two quadratic multiplies, sum and rounding,
// reciprocal multiply, back-multiply, correction) to its output word.
// One word per cycle is accepted while m_tready stays high.
// Each stage holds when the stage after it is full and stalled; empty stages
// keep filling, so a stalled output still takes input until the pipe is full.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module wavelength_to_rgb
    import wtr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [13:0] wavelength
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [15:0] red, [31:16] green,
                                           // [47:32] blue, [48] out_of_range
);

    pipe_ctl_t           ctl;
    logic [WL_W-1:0]     wl;
    logic                oor_in;
    logic [NSTG-1:0]     oor_reg;
    logic [NSTG-1:0]     oor_next;
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;

    assign wl     = s_tdata[WL_W-1:0];
    assign oor_in = (wl < WL_LO) || (wl > WL_HI);

    wtr_pipe_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    wtr_chan #(.CH(CH_RED)) u_red (
        .aclk  (aclk),
        .ctl   (ctl),
        .wl    (wl),
        .oor   (oor_in),
        .value (red)
    );

    wtr_chan #(.CH(CH_GREEN)) u_green (
        .aclk  (aclk),
        .ctl   (ctl),
        .wl    (wl),
        .oor   (oor_in),
        .value (green)
    );

    wtr_chan #(.CH(CH_BLUE)) u_blue (
        .aclk  (aclk),
        .ctl   (ctl),
        .wl    (wl),
        .oor   (oor_in),
        .value (blue)
    );

    // carry the range flag alongside the channel stages
    always_comb begin
        oor_next[0] = oor_in;
        for (int i = 1; i < NSTG; i++) begin
            oor_next[i] = oor_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (ctl.load[i]) begin
                oor_reg[i] <= oor_next[i];
            end
        end
    end

    assign m_tdata = {{(M_TDATA_W - 3 * OUT_BITS - 1){1'b0}}, oor_reg[NSTG-1],
                      blue, green, red};

endmodule

/* sv/wtr_pipe_ctl.sv */
// ----------------------------------------------------------------------------
// wtr_pipe_ctl: valid tracking and load enables for the datapath stages
// Each stage loads when it is empty or the stage after it loads.
// ----------------------------------------------------------------------------
module wtr_pipe_ctl
    import wtr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output pipe_ctl_t ctl
);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] rdy;

    always_comb begin
        rdy[NSTG-1] = ~valid_reg[NSTG-1] | m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = ~valid_reg[i] | rdy[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (rdy[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = rdy;
    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NSTG-1];

endmodule

/* sv/wtr_chan.sv */
// ----------------------------------------------------------------------------
// wtr_chan: one color channel, band select through rounded quotient
// Band select, two multiply stages for the quadratic, then a reciprocal
// multiply with one remainder correction for the division by 100*D^2.
// ----------------------------------------------------------------------------
module wtr_chan
    import wtr_pkg::*;
#(
    parameter int CH = 0
)
(
    input  logic                aclk,
    input  pipe_ctl_t           ctl,
    input  logic [WL_W-1:0]     wl,
    input  logic                oor,
    output logic [OUT_BITS-1:0] value
);

    localparam int FIRST = ch_first(CH);
    localparam int NB    = ch_count(CH);

    band_k_t kt [2**SEL_W];

    for (genvar g = 0; g < 2**SEL_W; g++) begin : g_band
        if (g < NB) begin : g_used
            localparam band_k_t KB    = band_const(FIRST + g);
            localparam longint  RECIP = (longint'(1) << (RECIP_SH + int'(KB.sh))) /
                                        longint'(KB.q);
            // reciprocal sits in the lowest field of the band constants
            assign kt[g] = {KB[$bits(band_k_t)-1:R_W], R_W'(RECIP)};
        end else begin : g_unused
            assign kt[g] = '0;
        end
    end

    // Stage 1: band select, offset into band
    logic [2**SEL_W-1:0] hit;
    logic [SEL_W-1:0]    sel1_next, sel1_reg;
    logic                in1_next, in1_reg;
    logic [D_W-1:0]      d1_next, d1_reg;

    always_comb begin
        for (int g = 0; g < 2**SEL_W; g++) begin
            hit[g] = (wl >= kt[g].lo) && (kt[g].incl ? (wl <= kt[g].hi) : (wl < kt[g].hi));
        end
        // lowest band that matches wins
        sel1_next = '0;
        for (int g = 2**SEL_W - 1; g >= 0; g--) begin
            if (hit[g]) begin
                sel1_next = SEL_W'(g);
            end
        end
        in1_next = (|hit) & ~oor;
        d1_next  = D_W'(wl - kt[sel1_next].lo);
    end

    // Stage 2: m = b*D + c*d
    logic [SEL_W-1:0]      sel2_reg;
    logic                  in2_reg;
    logic [D_W-1:0]        d2_reg;
    logic signed [M_W-1:0] m2_next, m2_reg;
    logic signed [M_W-1:0] dm, cm;

    always_comb begin
        dm      = M_W'($signed({1'b0, d1_reg}));
        cm      = M_W'(kt[sel1_reg].c);
        m2_next = kt[sel1_reg].bd + dm * cm;
    end

    // Stage 3: p = d*m
    logic [SEL_W-1:0]      sel3_reg;
    logic                  in3_reg;
    logic signed [P_W-1:0] p3_next, p3_reg;
    logic signed [P_W-1:0] dp, mp;

    always_comb begin
        dp      = P_W'($signed({1'b0, d2_reg}));
        mp      = P_W'(m2_reg);
        p3_next = dp * mp;
    end

    // Stage 4: N = a*D^2 + p, flags, rounded dividend
    logic [SEL_W-1:0]      sel4_reg;
    logic                  zero4_next, zero4_reg;
    logic                  sat4_next, sat4_reg;
    logic [Y_W-1:0]        y4_next, y4_reg;
    logic signed [P_W-1:0] n4;

    always_comb begin
        n4         = kt[sel3_reg].a2 + p3_reg;
        zero4_next = ~in3_reg | n4[P_W-1] | (n4 == '0);
        sat4_next  = n4 >= $signed(P_W'(kt[sel3_reg].q));
        y4_next    = {n4[Q_W-1:0], {OUT_BITS{1'b0}}} + Y_W'(kt[sel3_reg].half);
    end

    // Stage 5: quotient estimate by reciprocal
    logic [SEL_W-1:0]  sel5_reg;
    logic              zero5_reg, sat5_reg;
    logic [Y_W-1:0]    y5_reg;
    logic [YS_W-1:0]   ys;
    logic [PROD_W-1:0] prod5_next, prod5_reg;

    always_comb begin
        ys         = YS_W'(y4_reg >> kt[sel4_reg].sh);
        prod5_next = PROD_W'(ys) * PROD_W'(kt[sel4_reg].r);
    end

    // Stage 6: back-multiply the estimate
    logic [SEL_W-1:0] sel6_reg;
    logic             zero6_reg, sat6_reg;
    logic [Y_W-1:0]   y6_reg;
    logic [QE_W-1:0]  qe6_next, qe6_reg;
    logic [QQ_W-1:0]  qq6_next, qq6_reg;

    always_comb begin
        qe6_next = prod5_reg[PROD_W-1:RECIP_SH];
        qq6_next = QQ_W'(qe6_next) * QQ_W'(kt[sel5_reg].q);
    end

    // Stage 7: correct by one, saturate
    logic [QQ_W-1:0]     rem;
    logic [QE_W-1:0]     qf;
    logic [OUT_BITS-1:0] value_next, value_reg;

    always_comb begin
        rem = QQ_W'(y6_reg) - qq6_reg;
        qf  = qe6_reg + QE_W'(rem >= QQ_W'(kt[sel6_reg].q));
        if (zero6_reg) begin
            value_next = '0;
        end else if (sat6_reg | qf[QE_W-1]) begin
            value_next = '1;
        end else begin
            value_next = qf[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            sel1_reg <= sel1_next;
            in1_reg  <= in1_next;
            d1_reg   <= d1_next;
        end
        if (ctl.load[1]) begin
            sel2_reg <= sel1_reg;
            in2_reg  <= in1_reg;
            d2_reg   <= d1_reg;
            m2_reg   <= m2_next;
        end
        if (ctl.load[2]) begin
            sel3_reg <= sel2_reg;
            in3_reg  <= in2_reg;
            p3_reg   <= p3_next;
        end
        if (ctl.load[3]) begin
            sel4_reg  <= sel3_reg;
            zero4_reg <= zero4_next;
            sat4_reg  <= sat4_next;
            y4_reg    <= y4_next;
        end
        if (ctl.load[4]) begin
            sel5_reg  <= sel4_reg;
            zero5_reg <= zero4_reg;
            sat5_reg  <= sat4_reg;
            y5_reg    <= y4_reg;
            prod5_reg <= prod5_next;
        end
        if (ctl.load[5]) begin
            sel6_reg  <= sel5_reg;
            zero6_reg <= zero5_reg;
            sat6_reg  <= sat5_reg;
            y6_reg    <= y5_reg;
            qe6_reg   <= qe6_next;
            qq6_reg   <= qq6_next;
        end
        if (ctl.load[6]) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
